/* rtl/core/cts_pkg.sv */
// shared constants, codes and structs for the core cluster tier selector
package cts_pkg;

  localparam int MAX_CORES = 16;
  localparam int IDX_W     = $clog2(MAX_CORES);
  localparam int CNT_W     = $clog2(MAX_CORES + 1);
  localparam int FREQ_W    = 24;
  localparam int MASK_W    = 16;
  localparam int TCNT_W    = 5;
  localparam int STATUS_W  = 2;

  localparam logic [FREQ_W-1:0] HEAVY_MIN_RESET = 24'd1800000;

  localparam logic [STATUS_W-1:0] ST_PINNED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NODATA = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HOMOG  = 2'd3;

  typedef struct packed {
    logic             heavy;
    logic [CNT_W-1:0] cores;
    logic             any_freq;
  } start_info_t;

  typedef struct packed {
    logic                pinned;
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   core_mask;
    logic [FREQ_W-1:0]   target;
    logic [TCNT_W-1:0]   tiers;
    logic [TCNT_W-1:0]   selected;
  } result_t;

endpackage

/* rtl/core/cts_freq_mem.sv */
// per-core frequency store, one write and one registered read port
module cts_freq_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [cts_pkg::IDX_W-1:0]      waddr,
  input  logic [cts_pkg::FREQ_W-1:0]     wdata,
  input  logic [cts_pkg::IDX_W-1:0]      raddr,
  output logic [cts_pkg::FREQ_W-1:0]     rdata
);

  logic [cts_pkg::FREQ_W-1:0] mem [cts_pkg::MAX_CORES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cts_tier_seq.sv */
// tier ranking and target selection sequencer around one shared comparator
module cts_tier_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  cts_pkg::start_info_t             start_info,
  input  logic [cts_pkg::FREQ_W-1:0]       thr,
  output logic [cts_pkg::IDX_W-1:0]        mem_raddr,
  input  logic [cts_pkg::FREQ_W-1:0]       mem_rdata,
  output logic                             busy,
  output logic                             res_valid,
  input  logic                             res_take,
  output cts_pkg::result_t                 res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_LD   = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_PICK = 4'd4;
  localparam logic [3:0] S_TGT  = 4'd5;
  localparam logic [3:0] S_MRD  = 4'd6;
  localparam logic [3:0] S_MCMP = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int CW = cts_pkg::CNT_W;
  localparam int IW = cts_pkg::IDX_W;
  localparam int FW = cts_pkg::FREQ_W;

  logic [3:0]                      state;
  logic                            heavy;
  logic                            any_freq;
  logic [CW-1:0]                   cores;
  logic [CW-1:0]                   i;
  logic [CW-1:0]                   j;
  logic [CW-1:0]                   n;
  logic [CW-1:0]                   r;
  logic [FW-1:0]                   fi;
  logic [FW-1:0]                   tgt;
  logic [FW-1:0]                   tiers [cts_pkg::MAX_CORES];
  logic [cts_pkg::STATUS_W-1:0]    st;
  logic [cts_pkg::MASK_W-1:0]      mask;
  logic [cts_pkg::TCNT_W-1:0]      sel;

  logic [IW-1:0]                   tidx;
  logic [FW-1:0]                   cmp_a;
  logic [FW-1:0]                   cmp_b;
  logic                            cmp_eq;
  logic                            cmp_lt;
  logic                            ins;
  logic [CW-1:0]                   half;
  logic [CW-1:0]                   rank_pick;
  logic [cts_pkg::STATUS_W-1:0]    st_pick;

  assign tidx      = (state == S_SCAN) ? j[IW-1:0] : r[IW-1:0];
  assign mem_raddr = i[IW-1:0];
  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // the one comparator, operands chosen by the sequencer step
  always_comb begin
    case (state)
      S_SCAN: begin
        cmp_a = tiers[tidx];
        cmp_b = fi;
      end
      S_PICK: begin
        cmp_a = tiers[0];
        cmp_b = thr;
      end
      S_MCMP: begin
        cmp_a = mem_rdata;
        cmp_b = tgt;
      end
      default: begin
        cmp_a = fi;
        cmp_b = tgt;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  // new tier goes in at j when the row ends or the entry there is larger
  assign ins  = (j == n) || (!cmp_eq && !cmp_lt);
  assign half = (n - CW'(2)) >> 1;

  always_comb begin
    if (!heavy || !cmp_lt) begin
      rank_pick = '0;
    end else if (n == CW'(2)) begin
      rank_pick = CW'(1);
    end else begin
      rank_pick = half + CW'(1);
    end
    // never settle on the top tier when there are three or more
    if ((n >= CW'(3)) && (rank_pick == n - CW'(1))) begin
      rank_pick = half;
    end
  end

  always_comb begin
    if (cores <= CW'(1)) begin
      st_pick = cts_pkg::ST_FEW;
    end else if (!any_freq) begin
      st_pick = cts_pkg::ST_NODATA;
    end else if (n <= CW'(1)) begin
      st_pick = cts_pkg::ST_HOMOG;
    end else begin
      st_pick = cts_pkg::ST_PINNED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            heavy    <= start_info.heavy;
            cores    <= start_info.cores;
            any_freq <= start_info.any_freq;
            i        <= '0;
            n        <= '0;
            mask     <= '0;
            sel      <= '0;
            tgt      <= '0;
            state    <= S_RD;
          end
        end
        S_RD: begin
          if (i == cores) begin
            state <= S_PICK;
          end else begin
            state <= S_LD;
          end
        end
        S_LD: begin
          fi <= mem_rdata;
          j  <= '0;
          if (mem_rdata == '0) begin
            i     <= i + CW'(1);
            state <= S_RD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ins) begin
            if (j == '0) begin
              tiers[0] <= fi;
            end
            for (int k = 1; k < cts_pkg::MAX_CORES; k++) begin
              if (CW'(k) == j) begin
                tiers[k] <= fi;
              end else if ((CW'(k) > j) && (CW'(k) <= n)) begin
                tiers[k] <= tiers[k-1];
              end
            end
            n     <= n + CW'(1);
            i     <= i + CW'(1);
            state <= S_RD;
          end else if (cmp_eq) begin
            i     <= i + CW'(1);
            state <= S_RD;
          end else begin
            j <= j + CW'(1);
          end
        end
        S_PICK: begin
          st <= st_pick;
          r  <= rank_pick;
          if (st_pick == cts_pkg::ST_PINNED) begin
            state <= S_TGT;
          end else begin
            state <= S_DONE;
          end
        end
        S_TGT: begin
          tgt   <= tiers[tidx];
          i     <= '0;
          state <= S_MRD;
        end
        S_MRD: begin
          if (i == cores) begin
            if (sel == '0) begin
              st   <= cts_pkg::ST_HOMOG;
              tgt  <= '0;
              mask <= '0;
            end
            state <= S_DONE;
          end else begin
            state <= S_MCMP;
          end
        end
        S_MCMP: begin
          if (cmp_eq) begin
            mask <= mask | (cts_pkg::MASK_W'(1) << i);
            if (sel != '1) begin
              sel <= sel + cts_pkg::TCNT_W'(1);
            end
          end
          i     <= i + CW'(1);
          state <= S_MRD;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.pinned    = (st == cts_pkg::ST_PINNED);
  assign res.status    = st;
  assign res.core_mask = mask;
  assign res.target    = tgt;
  assign res.tiers     = cts_pkg::TCNT_W'(n);
  assign res.selected  = sel;

`ifndef SYNTHESIS
  a_tiers_within_cores: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (n <= cores))
    else $error("tier count exceeds loaded cores");

  a_pinned_has_cores: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (st == cts_pkg::ST_PINNED)) |-> (sel != '0))
    else $error("pinned result with no selected core");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("start while ranking in progress");

  a_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (fi != '0))
    else $error("zero frequency entered tier scan");
`endif

endmodule

/* rtl/core/core_cluster_tier_selector.sv */
// top level: item loading, threshold register and result output register
// a non-final item is taken whenever the input is not stalled; the final item of N stored cores starts the
// ranking, and the input stays stalled until its result moves into the output register
// the target and mask pass over the store runs only when pinned; one shared comparator walks the tier row
// reset clears counts, flags and output valid and loads threshold 1800000;
// store contents are undefined until written and get no clearing pass
module core_cluster_tier_selector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cts_pkg::FREQ_W-1:0]         core_max_freq_khz,
  input  logic                               last_core,
  input  logic                               heavy_load,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               pinned,
  output logic [cts_pkg::STATUS_W-1:0]       status,
  output logic [cts_pkg::MASK_W-1:0]         core_mask,
  output logic [cts_pkg::FREQ_W-1:0]         target_khz,
  output logic [cts_pkg::TCNT_W-1:0]         tier_count,
  output logic [cts_pkg::TCNT_W-1:0]         chosen_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cts_pkg::FREQ_W-1:0]         cfg_data
);

  localparam int CW = cts_pkg::CNT_W;

  logic [cts_pkg::FREQ_W-1:0]   heavy_min;
  logic [CW-1:0]                cores_loaded;
  logic                         any_freq_seen;
  logic [CW-1:0]                cores_after;
  logic                         any_after;
  logic                         accept;
  logic                         store_we;
  logic                         start;
  cts_pkg::start_info_t         start_info;
  logic [cts_pkg::IDX_W-1:0]    mem_raddr;
  logic [cts_pkg::FREQ_W-1:0]   mem_rdata;
  logic                         seq_busy;
  logic                         res_valid;
  logic                         res_take;
  cts_pkg::result_t             res;

  assign cfg_ready = 1'b1;
  assign in_stall  = seq_busy;
  assign accept    = in_valid && !in_stall;
  // cores past the limit still carry their last_core and load bits
  assign store_we  = accept && (cores_loaded < CW'(cts_pkg::MAX_CORES));

  assign cores_after = store_we ? (cores_loaded + CW'(1)) : cores_loaded;
  assign any_after   = any_freq_seen || (store_we && (core_max_freq_khz != '0));

  assign start               = accept && last_core;
  assign start_info.heavy    = heavy_load;
  assign start_info.cores    = cores_after;
  assign start_info.any_freq = any_after;

  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      heavy_min <= cts_pkg::HEAVY_MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heavy_min <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cores_loaded  <= '0;
      any_freq_seen <= 1'b0;
    end else if (accept) begin
      if (last_core) begin
        cores_loaded  <= '0;
        any_freq_seen <= 1'b0;
      end else begin
        cores_loaded  <= cores_after;
        any_freq_seen <= any_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      pinned       <= res.pinned;
      status       <= res.status;
      core_mask    <= res.core_mask;
      target_khz   <= res.target;
      tier_count   <= res.tiers;
      chosen_count <= res.selected;
    end
  end

  cts_freq_mem u_mem (
    .clk   (clk),
    .we    (store_we),
    .waddr (cores_loaded[cts_pkg::IDX_W-1:0]),
    .wdata (core_max_freq_khz),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cts_tier_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_info (start_info),
    .thr        (heavy_min),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .busy       (seq_busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

`ifndef SYNTHESIS
  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (accept && last_core) |=> in_stall)
    else $error("input not held off after final item");

  a_take_shows_result: assert property (@(posedge clk) disable iff (rst)
    res_take |=> out_valid)
    else $error("result taken but not presented");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    cores_loaded <= CW'(cts_pkg::MAX_CORES))
    else $error("core count beyond limit");
`endif

endmodule
